FILE: design/dnbf_pkg.sv
// Package: constants, types and functions for the DNS name Bloom filter check.
package dnbf_pkg;

   localparam int FilterBytesDefault  = 16384;
   localparam int MaxNameBytesDefault = 46;
   localparam int HashCountDefault    = 7;

   localparam int BitCountWidth = 18;
   localparam logic [BitCountWidth-1:0] BitCountReset = 18'd124616;

   localparam logic [31:0] MmC1 = 32'hcc9e2d51;
   localparam logic [31:0] MmC2 = 32'h1b873593;
   localparam logic [31:0] MmN  = 32'he6546b64;
   localparam logic [31:0] MmF1 = 32'h85ebca6b;
   localparam logic [31:0] MmF2 = 32'hc2b2ae35;

   localparam logic OpWrite = 1'b0;
   localparam logic OpName  = 1'b1;

   localparam logic VerdictPass = 1'b0;
   localparam logic VerdictDrop = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIX_MUL1,
      ST_MIX_MUL2,
      ST_MIX_ROUND,
      ST_TAIL_MUL1,
      ST_TAIL_MUL2,
      ST_FIN_MUL1,
      ST_FIN_MUL2,
      ST_FIN_MOD,
      ST_FIN_READ,
      ST_FIN_TEST,
      ST_OUT
   } state_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

endpackage

FILE: design/dnbf_if.sv
// Valid/ready channel interface carrying one item.
interface dnbf_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

FILE: design/dns_name_bloom_filter_check_core.sv
// Top level of the DNS query name Bloom filter check.
//
// Each request item is one filter byte write or one query name byte. A write
// is done in the idle state and leaves the block in idle. A name byte that
// does not complete a word passes through the round state, which only checks
// the name end. The fourth byte of a word runs the scramble and then the
// HASH_COUNT rounds, which share one 32x32 multiplier. At the name end the
// hashes are finished one at a time, after an optional tail scramble, until
// one tests a clear bit or a bit beyond the store. Each hash takes two fmix
// multiplies, a bit-serial modulo over its 32 bits, a store read and a test.
// After reset the block clears the filter store one byte per cycle, over all
// FILTER_BYTES bytes, and accepts no item meanwhile. A result item waits in
// its output register until taken.
module dns_name_bloom_filter_check_core
   import dnbf_pkg::*;
#(
   parameter int FILTER_BYTES   = FilterBytesDefault,
   parameter int MAX_NAME_BYTES = MaxNameBytesDefault,
   parameter int HASH_COUNT     = HashCountDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [BitCountWidth-1:0]  csr_write_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [13:0]               req_filter_address,
   input  logic [7:0]                req_filter_data,
   input  logic [7:0]                req_name_byte,
   input  logic                      req_last_of_packet,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_verdict
);

   localparam int AddrWidth = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
   localparam int LenWidth  = $clog2(MAX_NAME_BYTES + 1);
   localparam int HashWidth = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
   localparam int ClrWidth  = $clog2(FILTER_BYTES + 1);
   localparam logic [32:0] AddrRecip =
      33'(((64'd1 << 32) + 64'(FILTER_BYTES) - 64'd1) / 64'(FILTER_BYTES));

   logic [7:0] store_mem [FILTER_BYTES];
   logic [7:0] store_rd_ff;

   logic [31:0]         hash_ff [HASH_COUNT];
   logic [31:0]         hash_in [HASH_COUNT];
   logic [31:0]         part_ff, part_in;
   logic [LenWidth-1:0] len_ff, len_in;
   logic                skip_ff, skip_in;
   logic                last_ff, last_in;
   logic [BitCountWidth-1:0] count_ff;
   state_type           state_ff, state_in;
   logic [HashWidth-1:0] idx_ff, idx_in;
   logic [31:0]         k_ff, k_in;
   logic [31:0]         h_ff, h_in;
   logic [31:0]         rem_ff, rem_in;
   logic [5:0]          bitpos_ff, bitpos_in;
   logic [ClrWidth-1:0] clr_ff;
   logic                clearing;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_verdict_ff, rsp_verdict_in;

   logic [31:0] mul_a, mul_b, mul_p;
   logic        wr_en;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   logic [7:0]  wr_data;
   logic [BitCountWidth-1:0] modulus;
   logic [32:0] rem_shift;
   logic [7:0]  in_byte;
   logic        accept;
   logic [31:0] hx;
   logic [46:0] addr_prod;
   logic [13:0] addr_quot;
   logic [31:0] addr_mod;

   assign mul_p   = mul_a * mul_b;
   assign modulus = (count_ff == '0) ? BitCountWidth'(1) : count_ff;
   assign accept  = req_valid && req_ready;
   assign in_byte = req_name_byte;
   assign clearing = (clr_ff != ClrWidth'(FILTER_BYTES));

   // write address modulo FILTER_BYTES by reciprocal multiply
   assign addr_prod = 47'(req_filter_address) * 47'(AddrRecip);
   assign addr_quot = addr_prod[45:32];
   assign addr_mod  = 32'(req_filter_address) - 32'(addr_quot) * 32'(FILTER_BYTES);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      store_rd_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clearing) begin
         clr_ff <= clr_ff + ClrWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         for (int i = 0; i < HASH_COUNT; i++) hash_ff[i] <= 32'(i);
         part_ff        <= '0;
         len_ff         <= '0;
         skip_ff        <= 1'b0;
         count_ff       <= BitCountReset;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         part_ff      <= part_in;
         len_ff       <= len_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
      end
      last_ff        <= last_in;
      idx_ff         <= idx_in;
      k_ff           <= k_in;
      h_ff           <= h_in;
      rem_ff         <= rem_in;
      bitpos_ff      <= bitpos_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   always_comb begin
      state_in       = state_ff;
      hash_in        = hash_ff;
      part_in        = part_ff;
      len_in         = len_ff;
      skip_in        = skip_ff;
      last_in        = last_ff;
      idx_in         = idx_ff;
      k_in           = k_ff;
      h_in           = h_ff;
      rem_in         = rem_ff;
      bitpos_in      = bitpos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      mul_a          = k_ff;
      mul_b          = MmC1;
      wr_en          = clearing;
      wr_addr        = clr_ff[AddrWidth-1:0];
      wr_data        = '0;
      rd_addr        = rem_ff[AddrWidth+2:3];
      req_ready      = 1'b0;
      rem_shift      = '0;
      hx             = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = !clearing && !(rsp_valid_ff && !rsp_ready);
            if (accept) begin
               last_in = req_last_of_packet;
               if (req_operation == OpWrite) begin
                  wr_en   = 1'b1;
                  wr_addr = addr_mod[AddrWidth-1:0];
                  wr_data = req_filter_data;
               end else if (skip_ff) begin
                  if (req_last_of_packet) skip_in = 1'b0;
               end else if (in_byte != 8'd0) begin
                  case (len_ff[1:0])
                     2'd0: part_in = part_ff | {24'd0, in_byte};
                     2'd1: part_in = part_ff | {16'd0, in_byte, 8'd0};
                     2'd2: part_in = part_ff | {8'd0, in_byte, 16'd0};
                     default: part_in = part_ff | {in_byte, 24'd0};
                  endcase
                  len_in = len_ff + LenWidth'(1);
                  if (len_ff[1:0] == 2'd3) begin
                     k_in     = part_ff | {in_byte, 24'd0};
                     state_in = ST_MIX_MUL1;
                  end else begin
                     state_in = ST_MIX_ROUND;
                     idx_in   = HashWidth'(HASH_COUNT - 1);
                     bitpos_in = 6'd1;
                  end
               end else begin
                  state_in  = (len_ff[1:0] != 2'd0) ? ST_TAIL_MUL1 : ST_FIN_MUL1;
                  k_in      = part_ff;
                  idx_in    = '0;
                  h_in      = hash_ff[0] ^ 32'(len_ff);
                  h_in      = h_in ^ (h_in >> 16);
                  if (len_ff[1:0] != 2'd0) h_in = hash_ff[0];
               end
            end
         end
         ST_MIX_MUL1: begin
            mul_a    = k_ff;
            mul_b    = MmC1;
            k_in     = rotl32(mul_p, 15);
            state_in = ST_MIX_MUL2;
         end
         ST_MIX_MUL2: begin
            mul_a     = k_ff;
            mul_b     = MmC2;
            k_in      = mul_p;
            part_in   = '0;
            idx_in    = '0;
            bitpos_in = 6'd0;
            state_in  = ST_MIX_ROUND;
         end
         ST_MIX_ROUND: begin
            // bitpos 1 marks a byte that only checks the name end
            if (bitpos_ff == 6'd0) begin
               mul_a = rotl32(hash_ff[idx_ff] ^ k_ff, 13);
               mul_b = 32'd5;
               hash_in[idx_ff] = mul_p + MmN;
            end
            if (bitpos_ff == 6'd0 && idx_ff != HashWidth'(HASH_COUNT - 1)) begin
               idx_in = idx_ff + HashWidth'(1);
            end else if (len_ff >= LenWidth'(MAX_NAME_BYTES)) begin
               idx_in   = '0;
               k_in     = part_ff;
               h_in     = (len_ff[1:0] != 2'd0) ? hash_in[0]
                        : ((hash_in[0] ^ 32'(len_ff)) ^
                           ((hash_in[0] ^ 32'(len_ff)) >> 16));
               state_in = (len_ff[1:0] != 2'd0) ? ST_TAIL_MUL1 : ST_FIN_MUL1;
            end else if (last_ff) begin
               for (int i = 0; i < HASH_COUNT; i++) hash_in[i] = 32'(i);
               part_in        = '0;
               len_in         = '0;
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = VerdictPass;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TAIL_MUL1: begin
            mul_a    = part_ff;
            mul_b    = MmC1;
            k_in     = rotl32(mul_p, 15);
            state_in = ST_TAIL_MUL2;
         end
         ST_TAIL_MUL2: begin
            mul_a    = k_ff;
            mul_b    = MmC2;
            k_in     = mul_p;
            hx       = hash_ff[idx_ff] ^ mul_p ^ 32'(len_ff);
            h_in     = hx ^ (hx >> 16);
            state_in = ST_FIN_MUL1;
         end
         ST_FIN_MUL1: begin
            mul_a    = h_ff;
            mul_b    = MmF1;
            h_in     = mul_p ^ (mul_p >> 13);
            state_in = ST_FIN_MUL2;
         end
         ST_FIN_MUL2: begin
            mul_a     = h_ff;
            mul_b     = MmF2;
            h_in      = mul_p ^ (mul_p >> 16);
            rem_in    = '0;
            bitpos_in = 6'd31;
            state_in  = ST_FIN_MOD;
         end
         ST_FIN_MOD: begin
            rem_shift = {rem_ff, h_ff[bitpos_ff[4:0]]};
            if (rem_shift >= 33'(modulus)) begin
               rem_in = 32'(rem_shift - 33'(modulus));
            end else begin
               rem_in = rem_shift[31:0];
            end
            bitpos_in = bitpos_ff - 6'd1;
            if (bitpos_ff == 6'd0) state_in = ST_FIN_READ;
         end
         ST_FIN_READ: begin
            state_in = ST_FIN_TEST;
         end
         ST_FIN_TEST: begin
            if (rem_ff[31:3] >= 29'(FILTER_BYTES)) begin
               rsp_verdict_in = VerdictPass;
               state_in       = ST_OUT;
            end else if (store_rd_ff[3'd7 - rem_ff[2:0]] == 1'b0) begin
               rsp_verdict_in = VerdictDrop;
               state_in       = ST_OUT;
            end else if (idx_ff == HashWidth'(HASH_COUNT - 1)) begin
               rsp_verdict_in = VerdictPass;
               state_in       = ST_OUT;
            end else begin
               idx_in = idx_ff + HashWidth'(1);
               if (len_ff[1:0] != 2'd0) begin
                  hx = hash_ff[idx_in] ^ k_ff ^ 32'(len_ff);
               end else begin
                  hx = hash_ff[idx_in] ^ 32'(len_ff);
               end
               h_in     = hx ^ (hx >> 16);
               state_in = ST_FIN_MUL1;
            end
         end
         ST_OUT: begin
            for (int i = 0; i < HASH_COUNT; i++) hash_in[i] = 32'(i);
            part_in      = '0;
            len_in       = '0;
            skip_in      = !last_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready) else $error("item accepted during store clear");
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LenWidth'(MAX_NAME_BYTES)) else $error("name length overflow");
   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == ST_OUT) |-> rsp_valid) else $error("verdict lost");
`endif

endmodule

FILE: test/tb_dns_name_bloom_filter_check_core.sv
// Testbench for the DNS query name Bloom filter check: directed and random items, self-checking.
module tb_dns_name_bloom_filter_check_core;
   import dnbf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StoreBytes  = FilterBytesDefault;
   localparam int NameMax     = MaxNameBytesDefault;
   localparam int Hashes      = HashCountDefault;
   localparam int SettleCycles = 2 + Hashes * 40 + 64;
   localparam longint CycleLimit = 3000000;

   typedef struct packed {
      logic       operation;
      logic [13:0] filter_address;
      logic [7:0] filter_data;
      logic [7:0] name_byte;
      logic       last_of_packet;
   } req_t;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [BitCountWidth-1:0] csr_write_data;

   dnbf_if #(.payload_type(req_t)) req_ch();
   dnbf_if #(.payload_type(logic)) rsp_ch();

   dns_name_bloom_filter_check_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_operation      (req_ch.payload.operation),
      .req_filter_address (req_ch.payload.filter_address),
      .req_filter_data    (req_ch.payload.filter_data),
      .req_name_byte      (req_ch.payload.name_byte),
      .req_last_of_packet (req_ch.payload.last_of_packet),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_verdict        (rsp_ch.payload)
   );

   // predictor state
   bit [7:0]  filter_bytes [StoreBytes];
   bit [31:0] name_hashes [Hashes];
   bit [31:0] pending_word;
   int unsigned name_len;
   bit        skip_packet;
   bit [BitCountWidth-1:0] bit_count;

   logic expected_verdicts[$];
   int  error_count;
   int  items_sent;
   int  verdicts_seen;
   int  drops_seen;
   int  burst_left;
   int  rsp_hold;
   longint cycle_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit [31:0] rot_left(bit [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic bit [31:0] mix_key(bit [31:0] k);
      k = k * MmC1;
      k = rot_left(k, 15);
      return k * MmC2;
   endfunction

   function automatic bit [31:0] final_mix(bit [31:0] h);
      h ^= h >> 16;
      h = h * MmF1;
      h ^= h >> 13;
      h = h * MmF2;
      h ^= h >> 16;
      return h;
   endfunction

   function automatic void restart_name();
      for (int s = 0; s < Hashes; s++) name_hashes[s] = s;
      pending_word = '0;
      name_len = 0;
   endfunction

   function automatic logic lookup_verdict();
      bit [31:0] modulus;
      bit [31:0] tail_key;
      bit [31:0] h;
      bit [31:0] bit_no;
      bit        tail;
      modulus = (bit_count == 0) ? 32'd1 : 32'(bit_count);
      tail = (name_len % 4) != 0;
      tail_key = tail ? mix_key(pending_word) : 32'd0;
      for (int s = 0; s < Hashes; s++) begin
         h = name_hashes[s];
         if (tail) h ^= tail_key;
         h ^= name_len;
         h = final_mix(h);
         bit_no = h % modulus;
         if ((bit_no >> 3) >= StoreBytes) return VerdictPass;
         if (filter_bytes[bit_no >> 3][7 - bit_no[2:0]] == 1'b0) return VerdictDrop;
      end
      return VerdictPass;
   endfunction

   // returns 1 when the item yields a verdict
   function automatic bit predict_verdict(req_t it, output logic verdict);
      bit [31:0] k;
      bit [31:0] h;
      verdict = VerdictPass;
      if (it.operation == OpWrite) begin
         filter_bytes[it.filter_address] = it.filter_data;
         return 0;
      end
      if (skip_packet) begin
         if (it.last_of_packet) skip_packet = 0;
         return 0;
      end
      if (it.name_byte != 0) begin
         pending_word |= 32'(it.name_byte) << (8 * (name_len % 4));
         if (name_len % 4 == 3) begin
            k = mix_key(pending_word);
            for (int s = 0; s < Hashes; s++) begin
               h = rot_left(name_hashes[s] ^ k, 13);
               name_hashes[s] = h * 32'd5 + MmN;
            end
            pending_word = '0;
         end
         name_len++;
         if (name_len < NameMax) begin
            if (!it.last_of_packet) return 0;
            restart_name();
            verdict = VerdictPass;
            return 1;
         end
      end
      verdict = lookup_verdict();
      restart_name();
      skip_packet = !it.last_of_packet;
      return 1;
   endfunction

   task automatic send_item(input req_t it);
      logic v;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      if (predict_verdict(it, v)) expected_verdicts.push_back(v);
   endtask

   function automatic req_t rand_item();
      req_t it;
      it.operation      = 1'($urandom_range(0, 1));
      it.filter_address = 14'($urandom_range(0, StoreBytes - 1));
      it.filter_data    = 8'($urandom_range(0, 255));
      it.name_byte      = 8'($urandom_range(0, 255));
      it.last_of_packet = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic write_filter(input int addr, input int data);
      req_t it;
      it = rand_item();
      it.operation = OpWrite;
      it.filter_address = 14'(addr);
      it.filter_data = 8'(data);
      send_item(it);
   endtask

   task automatic send_name_byte(input int b, input bit last);
      req_t it;
      it = rand_item();
      it.operation = OpName;
      it.name_byte = 8'(b);
      it.last_of_packet = last;
      send_item(it);
   endtask

   // name of len nonzero bytes, a terminator when len is below NameMax, then trailing bytes; last on the final item
   task automatic send_packet(input int len, input int trailing, input bit cut_short);
      int cut;
      cut = cut_short ? $urandom_range(0, (len > 0) ? len - 1 : 0) : -1;
      for (int i = 0; i < len; i++) begin
         if (i == cut && len > 0) begin
            send_name_byte($urandom_range(1, 255), 1'b1);
            return;
         end
         send_name_byte($urandom_range(1, 255),
                        (len >= NameMax) && (i == len - 1) && (trailing == 0));
      end
      if (len < NameMax)
         send_name_byte(8'h00, trailing == 0);
      for (int i = 0; i < trailing; i++)
         send_name_byte($urandom_range(0, 255), i == trailing - 1);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_bit_count(input int value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= BitCountWidth'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bit_count = BitCountWidth'(value);
   endtask

   // dense filter over the first bytes, mostly ones so both verdicts occur
   task automatic fill_filter(input int nbytes);
      for (int a = 0; a < nbytes; a++)
         write_filter(a, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 8'hff);
   endtask

   task automatic test_reset_count();
      send_packet(3, 0, 0);
      send_packet(0, 1, 0);
   endtask

   task automatic test_directed();
      set_bit_count(64);
      write_filter(StoreBytes - 1, 8'hff);
      write_filter(0, 8'h00);
      for (int a = 0; a < 8; a++) write_filter(a, 8'hff);
      send_packet(0, 0, 0);
      send_packet(1, 0, 0);
      send_packet(4, 2, 0);
      send_packet(5, 0, 0);
      send_name_byte(8'hff, 1'b0);
      send_name_byte(8'h01, 1'b1);
      send_packet(NameMax, 0, 0);
      send_packet(NameMax, 3, 0);
      send_packet(NameMax + 2, 0, 0);
   endtask

   task automatic test_count_extremes();
      set_bit_count(0);
      write_filter(0, 8'h80);
      send_packet(2, 0, 0);
      write_filter(0, 8'h7f);
      send_packet(2, 0, 0);
      set_bit_count(8);
      write_filter(0, 8'hff);
      send_packet(6, 1, 0);
      set_bit_count(131072);
      send_packet(7, 0, 0);
      set_bit_count((1 << BitCountWidth) - 1);
      send_packet(3, 0, 0);
      send_packet(9, 0, 0);
      send_packet(12, 0, 0);
   endtask

   task automatic test_backpressure();
      set_bit_count(96);
      fill_filter(12);
      rsp_hold = 3000;
      for (int p = 0; p < 6; p++) send_packet($urandom_range(0, 6), 0, 0);
      drain();
   endtask

   task automatic test_random(input int item_budget);
      int counts [6] = '{8, 64, 200, 256, 131072, 262143};
      int target;
      int len;
      target = items_sent + item_budget;
      while (items_sent < target) begin
         set_bit_count(counts[$urandom_range(0, 5)]);
         if (bit_count <= 256) fill_filter((bit_count + 7) / 8);
         for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 9))
               0: send_item(rand_item());
               1: write_filter($urandom_range(0, 31), $urandom_range(0, 255));
               2: send_packet($urandom_range(1, 10), $urandom_range(0, 2), 1);
               3: send_packet($urandom_range(40, 50), $urandom_range(0, 2), 0);
               default: begin
                  len = $urandom_range(0, 12);
                  send_packet(len, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0, 0);
               end
            endcase
         end
      end
   endtask

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      logic want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            verdicts_seen++;
            if (rsp_ch.payload == VerdictDrop) drops_seen++;
            if (expected_verdicts.size() == 0) begin
               $error("unexpected verdict: got %0b", rsp_ch.payload);
               error_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_ch.payload !== want) begin
                  $error("verdict mismatch: expected %0b actual %0b", want, rsp_ch.payload);
                  error_count++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ch.ready <= 1'b0;
         end else if ((cycle_count / 700) % 3 == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= $urandom_range(0, 3) != 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      error_count = 0;
      items_sent = 0;
      verdicts_seen = 0;
      drops_seen = 0;
      burst_left = 0;
      rsp_hold = 0;
      cycle_count = 0;
      foreach (filter_bytes[a]) filter_bytes[a] = '0;
      restart_name();
      skip_packet = 0;
      bit_count = BitCountReset;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_count();
      test_directed();
      test_count_extremes();
      test_backpressure();
      test_random(530);

      drain();
      $display("covered %0d items, %0d verdicts (%0d drop), bit counts 0 to 262143,",
               items_sent, verdicts_seen, drops_seen);
      $display("full and short names, cut packets, trailing bytes and output stalls");
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
